/* src/tbrl_pkg.sv */
// Types, constants and the microcode table of the token bucket rate limiter.
package tbrl_pkg;

   // Field widths.
   localparam int unsigned INTERVAL_W = 40;
   localparam int unsigned CAPACITY_W = 16;
   localparam int unsigned PERMITS_W  = 16;
   localparam int unsigned TIMEOUT_W  = 16;
   localparam int unsigned TIME_W     = 64;
   localparam int unsigned STORED_W   = 32;
   localparam int unsigned CSR_DATA_W = 40;
   localparam int unsigned CSR_INDEX_W = 2;

   // Derived widths of internal values.
   localparam int unsigned TMO_US_W   = 26;  // 16-bit ms times 1000
   localparam int unsigned DIV_CNT_W  = 6;   // counts the radix-4 divide steps
   localparam int unsigned PROD_W     = 56;  // 32 x 24 product
   localparam int unsigned BORROW_W   = 49;  // 48-bit product plus a 32-bit term
   localparam int unsigned STEP_W     = 4;

   // Constants.
   localparam logic [9:0] USEC_PER_MS = 10'd1000;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST_COUNT = 6'd43;  // 44 steps, 88 bits

   // Register reset values.
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 40'd256000000;
   localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 16'd1;
   localparam logic [INTERVAL_W-1:0] INTERVAL_MIN   = 40'd1;

   // Register indexes on the csr port.
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERVAL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY = 2'd1;

   // Request operations.
   localparam logic OP_ACQUIRE     = 1'b0;
   localparam logic OP_TRY_ACQUIRE = 1'b1;

   // Datapath operations selected by a control word.
   typedef enum logic [3:0] {
      UOP_CAPTURE,
      UOP_TRY,
      UOP_REFILL_INIT,
      UOP_DIV,
      UOP_CAP,
      UOP_SPEND,
      UOP_MUL_LO,
      UOP_MUL_HI,
      UOP_ADD_BORROW,
      UOP_COMMIT,
      UOP_OUTPUT
   } uop_type;

   // Jump conditions of a control word.
   typedef enum logic [2:0] {
      COND_NONE,
      COND_ACCEPT,
      COND_REFUSE,
      COND_NO_ELAPSED,
      COND_DIV_DONE,
      COND_OUT_FREE
   } cond_type;

   typedef logic [STEP_W-1:0] step_type;

   // One control word: operation, jump condition and target, and whether the
   // step repeats while its condition is false.
   typedef struct packed {
      uop_type  op;
      cond_type cond;
      logic     hold;
      step_type target;
   } ucode_type;

   // Program step addresses.
   localparam step_type STEP_IDLE        = 4'd0;
   localparam step_type STEP_TRY         = 4'd1;
   localparam step_type STEP_REFILL_INIT = 4'd2;
   localparam step_type STEP_DIV         = 4'd3;
   localparam step_type STEP_CAP         = 4'd4;
   localparam step_type STEP_SPEND       = 4'd5;
   localparam step_type STEP_MUL_LO      = 4'd6;
   localparam step_type STEP_MUL_HI      = 4'd7;
   localparam step_type STEP_ADD_BORROW  = 4'd8;
   localparam step_type STEP_COMMIT      = 4'd9;
   localparam step_type STEP_OUT         = 4'd10;

   // The microprogram: one read-only control word per step.
   function automatic ucode_type ucode_fetch(input step_type step);
      ucode_type w;
      begin
         case (step)
            STEP_IDLE:        w = '{UOP_CAPTURE,     COND_ACCEPT,     1'b1, STEP_TRY};
            STEP_TRY:         w = '{UOP_TRY,         COND_REFUSE,     1'b0, STEP_OUT};
            STEP_REFILL_INIT: w = '{UOP_REFILL_INIT, COND_NO_ELAPSED, 1'b0, STEP_SPEND};
            STEP_DIV:         w = '{UOP_DIV,         COND_DIV_DONE,   1'b1, STEP_CAP};
            STEP_CAP:         w = '{UOP_CAP,         COND_NONE,       1'b0, STEP_IDLE};
            STEP_SPEND:       w = '{UOP_SPEND,       COND_NONE,       1'b0, STEP_IDLE};
            STEP_MUL_LO:      w = '{UOP_MUL_LO,      COND_NONE,       1'b0, STEP_IDLE};
            STEP_MUL_HI:      w = '{UOP_MUL_HI,      COND_NONE,       1'b0, STEP_IDLE};
            STEP_ADD_BORROW:  w = '{UOP_ADD_BORROW,  COND_NONE,       1'b0, STEP_IDLE};
            STEP_COMMIT:      w = '{UOP_COMMIT,      COND_NONE,       1'b0, STEP_IDLE};
            STEP_OUT:         w = '{UOP_OUTPUT,      COND_OUT_FREE,   1'b1, STEP_IDLE};
            default:          w = '{UOP_OUTPUT,      COND_NONE,       1'b0, STEP_IDLE};
         endcase
         return w;
      end
   endfunction

endpackage

/* src/token_bucket_rate_limiter.sv */
// Token bucket rate limiter with borrowing, run by a microcoded sequencer.
//
// Requests come in as words on the req_ channel (valid/stall): a mode, a
// timestamp in microseconds, a permit count and a timeout in milliseconds.
// Each request gives exactly one result word on the rsp_ channel: a grant
// flag and the wait in microseconds. Elapsed time is turned into permits by
// a radix-4 restoring divider, and the borrow time by two passes through one
// 32 x 24 multiplier. A request that refills runs the try, refill, divide,
// cap, spend, two multiply, add and commit steps before its output step loads
// the result register; one that does not refill skips the divide and cap
// steps, and one refused in try mode goes from the try step straight to the
// output step. The sequencer is back at its idle step in the same cycle that
// the result register is loaded. The block accepts the next request once the
// sequencer returns to its idle step, even while the previous result still
// waits in the output register; a stalled result holds the sequencer at its
// output step until the receiver takes it. The csr_ port writes the interval
// (index 0) and the capacity (index 1); writing the capacity fills the bucket.
// Writes are to be made while idle; the block itself does not enforce this.
// Synchronous reset sets one permit per second, a capacity of one stored
// permit, a full bucket and a next free time of zero.
module token_bucket_rate_limiter
   import tbrl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_operation,
   input  logic [TIME_W-1:0]      req_now_us,
   input  logic [PERMITS_W-1:0]   req_requested_permits,
   input  logic [TIMEOUT_W-1:0]   req_timeout_ms,
   // Result channel.
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_granted,
   output logic [TIME_W-1:0]      rsp_wait_us,
   // Configuration port.
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // Configuration and bucket state.
   logic [INTERVAL_W-1:0] interval_ff, interval_in;
   logic [CAPACITY_W-1:0] capacity_ff, capacity_in;
   logic [STORED_W-1:0]   stored_ff, stored_in;
   logic [TIME_W-1:0]     next_free_ff, next_free_in;

   // Sequencer.
   step_type  step_ff, step_in;
   ucode_type uword;
   logic      cond_true;

   // Captured request.
   logic                  op_ff, op_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [PERMITS_W-1:0]  permits_ff, permits_in;
   logic [TMO_US_W-1:0]   tmo_us_ff, tmo_us_in;

   // Divider.
   logic [TIME_W-1:0]     dvd_ff, dvd_in;
   logic [INTERVAL_W-1:0] rem_ff, rem_in;
   logic [STORED_W-1:0]   quo_ff, quo_in;
   logic                  sat_ff, sat_in;
   logic [DIV_CNT_W-1:0]  count_ff, count_in;

   // Borrow arithmetic.
   logic [STORED_W-1:0]   short_ff, short_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [BORROW_W-1:0]   borrow_ff, borrow_in;

   // Result staging and output register.
   logic                  res_granted_ff, res_granted_in;
   logic [TIME_W-1:0]     res_wait_ff, res_wait_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_granted_ff, rsp_granted_in;
   logic [TIME_W-1:0]     rsp_wait_ff, rsp_wait_in;

   // Datapath intermediate values.
   logic                  req_accept;
   logic                  out_free;
   logic [TIME_W:0]       lim_sum;
   logic [TIME_W-1:0]     limit;
   logic                  refuse;
   logic                  no_elapsed;
   logic [INTERVAL_W:0]   div_r1, div_r2;
   logic [INTERVAL_W-1:0] div_p1, div_p2;
   logic                  div_q1, div_q2;
   logic [STORED_W-1:0]   refill;
   logic [STORED_W:0]     cap_sum;
   logic [STORED_W-1:0]   cap_q;
   logic [STORED_W-1:0]   want;
   logic [STORED_W-1:0]   spend;
   logic [23:0]           mul_b;
   logic [PROD_W-1:0]     mul_p;
   logic [TIME_W:0]       commit_sum;

   // Handshake status.
   assign req_stall  = (step_ff != STEP_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_granted = rsp_granted_ff;
   assign rsp_wait_us = rsp_wait_ff;

   // Try mode limit: the timestamp plus the timeout, saturating.
   always_comb begin
      lim_sum = {1'b0, now_ff} + (TIME_W + 1)'(tmo_us_ff);
      limit   = lim_sum[TIME_W] ? '1 : lim_sum[TIME_W-1:0];
      refuse  = (op_ff == OP_TRY_ACQUIRE) && (next_free_ff > limit);
      no_elapsed = !(now_ff > next_free_ff);
   end

   // Two restoring divide steps per cycle over the elapsed time shifted by 24.
   always_comb begin
      div_r1 = {rem_ff, dvd_ff[TIME_W-1]};
      div_q1 = (div_r1 >= {1'b0, interval_ff});
      div_p1 = div_q1 ? INTERVAL_W'(div_r1 - {1'b0, interval_ff}) : div_r1[INTERVAL_W-1:0];
      div_r2 = {div_p1, dvd_ff[TIME_W-2]};
      div_q2 = (div_r2 >= {1'b0, interval_ff});
      div_p2 = div_q2 ? INTERVAL_W'(div_r2 - {1'b0, interval_ff}) : div_r2[INTERVAL_W-1:0];
      refill = sat_ff ? '1 : quo_ff;
   end

   // Refill cap, spend and the shared multiplier.
   always_comb begin
      cap_sum = {1'b0, stored_ff} + {1'b0, refill};
      cap_q   = {capacity_ff, 16'h0000};
      want    = {permits_ff, 16'h0000};
      spend   = (want < stored_ff) ? want : stored_ff;
      mul_b   = (uword.op == UOP_MUL_HI) ? {8'h00, interval_ff[INTERVAL_W-1:24]}
                                          : interval_ff[23:0];
      mul_p   = PROD_W'(short_ff) * PROD_W'(mul_b);
      commit_sum = {1'b0, next_free_ff} + (TIME_W + 1)'(borrow_ff);
   end

   // Microcode fetch and step sequencing.
   always_comb begin
      uword = ucode_fetch(step_ff);
      case (uword.cond)
         COND_ACCEPT:     cond_true = req_accept;
         COND_REFUSE:     cond_true = refuse;
         COND_NO_ELAPSED: cond_true = no_elapsed;
         COND_DIV_DONE:   cond_true = (count_ff == '0);
         COND_OUT_FREE:   cond_true = out_free;
         default:         cond_true = 1'b0;
      endcase
      if (cond_true) begin
         step_in = uword.target;
      end else if (uword.hold) begin
         step_in = step_ff;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   // Datapath: the control word's operation updates its registers.
   always_comb begin
      interval_in    = interval_ff;
      capacity_in    = capacity_ff;
      stored_in      = stored_ff;
      next_free_in   = next_free_ff;
      op_in          = op_ff;
      now_in         = now_ff;
      permits_in     = permits_ff;
      tmo_us_in      = tmo_us_ff;
      dvd_in         = dvd_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      sat_in         = sat_ff;
      count_in       = count_ff;
      short_in       = short_ff;
      prod_in        = prod_ff;
      borrow_in      = borrow_ff;
      res_granted_in = res_granted_ff;
      res_wait_in    = res_wait_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_wait_in    = rsp_wait_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      case (uword.op)
         UOP_CAPTURE: begin
            if (req_accept) begin
               op_in      = req_operation;
               now_in     = req_now_us;
               permits_in = req_requested_permits;
               tmo_us_in  = TMO_US_W'(req_timeout_ms) * TMO_US_W'(USEC_PER_MS);
            end
         end
         UOP_TRY: begin
            // A refused request leaves these values in place.
            res_granted_in = 1'b0;
            res_wait_in    = '0;
         end
         UOP_REFILL_INIT: begin
            dvd_in   = now_ff - next_free_ff;
            rem_in   = '0;
            quo_in   = '0;
            sat_in   = 1'b0;
            count_in = DIV_LAST_COUNT;
         end
         UOP_DIV: begin
            dvd_in = {dvd_ff[TIME_W-3:0], 2'b00};
            rem_in = div_p2;
            quo_in = {quo_ff[STORED_W-3:0], div_q1, div_q2};
            sat_in = sat_ff || quo_ff[STORED_W-1] || quo_ff[STORED_W-2];
            if (count_ff != '0) begin
               count_in = count_ff - 1'b1;
            end
         end
         UOP_CAP: begin
            stored_in    = (cap_sum < {1'b0, cap_q}) ? cap_sum[STORED_W-1:0] : cap_q;
            next_free_in = now_ff;
         end
         UOP_SPEND: begin
            res_granted_in = 1'b1;
            res_wait_in    = next_free_ff - now_ff;
            short_in       = want - spend;
            stored_in      = stored_ff - spend;
         end
         UOP_MUL_LO: begin
            prod_in = mul_p;
         end
         UOP_MUL_HI: begin
            borrow_in = BORROW_W'(prod_ff[PROD_W-1:24]);
            prod_in   = mul_p;
         end
         UOP_ADD_BORROW: begin
            borrow_in = BORROW_W'(prod_ff[47:0]) + borrow_ff;
         end
         UOP_COMMIT: begin
            next_free_in = commit_sum[TIME_W] ? '1 : commit_sum[TIME_W-1:0];
         end
         UOP_OUTPUT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = res_granted_ff;
               rsp_wait_in    = res_wait_ff;
            end
         end
         default: begin
         end
      endcase

      // Register writes; a zero interval is stored as the minimum.
      if (csr_write_enable) begin
         case (csr_index)
            CSR_INTERVAL: begin
               interval_in = (csr_write_data == '0) ? INTERVAL_MIN : csr_write_data;
            end
            CSR_CAPACITY: begin
               capacity_in = csr_write_data[CAPACITY_W-1:0];
               stored_in   = {csr_write_data[CAPACITY_W-1:0], 16'h0000};
            end
            default: begin
            end
         endcase
      end
   end

   // Control and bucket state, set to their reset values by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
         interval_ff  <= INTERVAL_RESET;
         capacity_ff  <= CAPACITY_RESET;
         stored_ff    <= {CAPACITY_RESET, 16'h0000};
         next_free_ff <= '0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         interval_ff  <= interval_in;
         capacity_ff  <= capacity_in;
         stored_ff    <= stored_in;
         next_free_ff <= next_free_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      now_ff         <= now_in;
      permits_ff     <= permits_in;
      tmo_us_ff      <= tmo_us_in;
      dvd_ff         <= dvd_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      sat_ff         <= sat_in;
      count_ff       <= count_in;
      short_ff       <= short_in;
      prod_ff        <= prod_in;
      borrow_ff      <= borrow_in;
      res_granted_ff <= res_granted_in;
      res_wait_ff    <= res_wait_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_wait_ff    <= rsp_wait_in;
   end

endmodule
